// File: hw/rtl/itl_pkg.sv
// itl_pkg: shared constants and types for the indentation token lexer.
// No dependencies; used by itl_cell and indentation_token_lexer.
package itl_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int MAX_TOKENS      = 64;
    localparam int LEVEL_W         = 16;
    localparam int TAB_W           = 5;
    localparam int DATA_W          = 32;

    localparam logic [TAB_W-1:0]   TAB_RESET = 5'd4;
    localparam logic [LEVEL_W-1:0] WIDTH_MAX = 16'hFFFF;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_NEWLINE = 2'd0,
        KIND_INDENT  = 2'd1,
        KIND_DEDENT  = 2'd2
    } t_kind;

    // shift command broadcast along the stack chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

// File: hw/rtl/indentation_token_lexer.sv
// indentation_token_lexer: offside-rule NEWLINE/INDENT/DEDENT token generator.
// Depends on itl_pkg and itl_cell (one cell per stack entry above the base).
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_char_code, i_at_end, i_externals_enabled
//  out       output     o_out_valid / i_out_stall  o_token_kind, o_indent_level, o_last
//  cfg       input      APB psel/penable/pready    paddr, pwdata, prdata (tab_width)
//
// A byte that yields no token is taken without leaving idle. A line that
// indents goes straight to the emit phase; any other decided line first pops
// one level at a time, then leaves the pop phase, then emits its tokens.
// End of input goes straight to the emit phase.
// Tokens leave through a single output register; a held stall delays them.
// o_in_stall is high from acceptance until the last token is loaded.
// Synchronous active-low reset; stack cells hold no reset, the base level is 0.
module indentation_token_lexer #(
    parameter int STACK_DEPTH = itl_pkg::STACK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_char_code,
    input  logic                         i_at_end,
    input  logic                         i_externals_enabled,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_token_kind,
    output logic [itl_pkg::LEVEL_W-1:0]  o_indent_level,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [itl_pkg::DATA_W-1:0]   pwdata,
    output logic [itl_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int CAP   = (STACK_DEPTH < itl_pkg::MAX_TOKENS) ? STACK_DEPTH
                                                               : itl_pkg::MAX_TOKENS;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int NCELL = CAP - 1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAP);
    localparam int LW = itl_pkg::LEVEL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EMIT
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_dedents, n_dedents;
    logic                    r_indent, n_indent;
    logic                    r_nl_sent, n_nl_sent;
    logic                    r_measuring, n_measuring;
    logic [LW-1:0]           r_width, n_width;
    logic                    r_end_handled, n_end_handled;
    logic [itl_pkg::TAB_W-1:0] r_tab_width;
    logic                    r_out_valid, n_out_valid;
    itl_pkg::t_kind          r_kind, n_kind;
    logic [LW-1:0]           r_level, n_level;
    logic                    r_last, n_last;

    itl_pkg::t_shift_ctl     w_ctl;
    logic [LW-1:0]           w_level [NCELL];
    logic [LW-1:0]           w_top;
    logic [LW:0]             w_sum;
    logic [LW-1:0]           w_sat;
    logic                    w_in_acc;
    logic                    w_slot_free;
    logic                    w_cfg_wr;

    // stack chain: cell 0 is the top entry, the base level is implicit
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [LW-1:0] w_above;
        logic [LW-1:0] w_below;
        if (g == 0) begin : g_head
            assign w_above = r_width;
        end else begin : g_mid
            assign w_above = w_level[g-1];
        end
        if (g == NCELL - 1) begin : g_tail
            assign w_below = w_level[g];
        end else begin : g_body
            assign w_below = w_level[g+1];
        end
        itl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_level      (w_level[g])
        );
    end

    assign w_top       = (r_count == CNT_ONE) ? '0 : w_level[0];
    assign w_sum       = {1'b0, r_width}
                       + ((i_char_code == itl_pkg::CHAR_SPACE) ? (LW+1)'(1)
                                                               : (LW+1)'(r_tab_width));
    assign w_sat       = w_sum[LW] ? itl_pkg::WIDTH_MAX : w_sum[LW-1:0];
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_cfg_wr    = psel && penable && pwrite && pready;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_dedents     = r_dedents;
        n_indent      = r_indent;
        n_nl_sent     = r_nl_sent;
        n_measuring   = r_measuring;
        n_width       = r_width;
        n_end_handled = r_end_handled;
        n_out_valid   = r_out_valid && i_out_stall;
        n_kind        = r_kind;
        n_level       = r_level;
        n_last        = r_last;
        w_ctl         = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_externals_enabled) begin
                    if (i_at_end && (r_measuring || !r_end_handled)) begin
                        // unwind to the base level
                        n_measuring   = 1'b0;
                        n_end_handled = 1'b1;
                        n_count       = CNT_ONE;
                        n_dedents     = r_count - CNT_ONE;
                        n_indent      = 1'b0;
                        n_nl_sent     = 1'b0;
                        n_state       = S_EMIT;
                    end else if (!i_at_end && !r_measuring) begin
                        if (i_char_code == itl_pkg::CHAR_LF) begin
                            n_measuring = 1'b1;
                            n_width     = '0;
                        end
                    end else if (!i_at_end) begin
                        if (i_char_code == itl_pkg::CHAR_LF) begin
                            n_width = '0;
                        end else if (i_char_code == itl_pkg::CHAR_SPACE ||
                                     i_char_code == itl_pkg::CHAR_TAB) begin
                            n_width = w_sat;
                        end else begin
                            n_measuring = 1'b0;
                            n_nl_sent   = 1'b0;
                            n_dedents   = '0;
                            if (r_width > w_top) begin
                                n_indent = 1'b1;
                                n_state  = S_EMIT;
                            end else begin
                                n_indent = 1'b0;
                                n_state  = S_POP;
                            end
                        end
                    end
                end
            end
            S_POP: begin
                if (r_count != CNT_ONE && w_top > r_width) begin
                    w_ctl.pop = 1'b1;
                    n_count   = r_count - CNT_ONE;
                    n_dedents = r_dedents + CNT_ONE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_level     = w_top;
                    if (!r_nl_sent) begin
                        n_kind    = itl_pkg::KIND_NEWLINE;
                        n_nl_sent = 1'b1;
                        n_last    = !r_indent && (r_dedents == '0);
                        if (r_indent && r_count < CNT_CAP) begin
                            w_ctl.push = 1'b1;
                            n_count    = r_count + CNT_ONE;
                        end
                        if (!r_indent && r_dedents == '0) begin
                            n_state = S_IDLE;
                        end
                    end else if (r_indent) begin
                        // top already reflects the push, or is unchanged when full
                        n_kind   = itl_pkg::KIND_INDENT;
                        n_last   = 1'b1;
                        n_indent = 1'b0;
                        n_state  = S_IDLE;
                    end else begin
                        n_kind    = itl_pkg::KIND_DEDENT;
                        n_dedents = r_dedents - CNT_ONE;
                        n_last    = (r_dedents == CNT_ONE);
                        if (r_dedents == CNT_ONE) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= CNT_ONE;
            r_dedents     <= '0;
            r_indent      <= 1'b0;
            r_nl_sent     <= 1'b0;
            r_measuring   <= 1'b0;
            r_width       <= '0;
            r_end_handled <= 1'b0;
            r_tab_width   <= itl_pkg::TAB_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_dedents     <= n_dedents;
            r_indent      <= n_indent;
            r_nl_sent     <= n_nl_sent;
            r_measuring   <= n_measuring;
            r_width       <= n_width;
            r_end_handled <= n_end_handled;
            r_out_valid   <= n_out_valid;
            if (w_cfg_wr && !paddr[2]) begin
                r_tab_width <= pwdata[itl_pkg::TAB_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_level <= n_level;
        r_last  <= n_last;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_token_kind   = r_kind;
    assign o_indent_level = r_level;
    assign o_last         = r_last;
    assign pready         = 1'b1;
    assign prdata         = paddr[2] ? '0
                          : {{(itl_pkg::DATA_W - itl_pkg::TAB_W){1'b0}}, r_tab_width};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_ONE) && (r_count <= CNT_CAP))
        else $error("stack count out of range");

    a_indent_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == itl_pkg::KIND_INDENT) |-> o_last)
        else $error("indent token not marked last");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_count <= $past(r_count)))
        else $error("stack grew while popping");

    a_newline_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_nl_sent && w_slot_free) |=>
            (o_out_valid && o_token_kind == itl_pkg::KIND_NEWLINE))
        else $error("newline not loaded into a free output slot");

endmodule

// File: hw/rtl/itl_cell.sv
// itl_cell: one entry of the shift-register level stack.
// Depends on itl_pkg (t_shift_ctl, LEVEL_W).
module itl_cell (
    input  logic                         i_clk,
    input  itl_pkg::t_shift_ctl          i_ctl,
    input  logic [itl_pkg::LEVEL_W-1:0]  i_from_above,
    input  logic [itl_pkg::LEVEL_W-1:0]  i_from_below,
    output logic [itl_pkg::LEVEL_W-1:0]  o_level
);

    logic [itl_pkg::LEVEL_W-1:0] r_level;

    // push moves entries away from the top, pop moves them towards it
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_level <= i_from_above;
        end else if (i_ctl.pop) begin
            r_level <= i_from_below;
        end
    end

    assign o_level = r_level;

endmodule

// File: tb/sv/tb_indentation_token_lexer.sv
// tb_indentation_token_lexer: self-checking bench for the offside-rule layout lexer.
// Depends on itl_pkg and indentation_token_lexer; predicts NEWLINE/INDENT/DEDENT
// tokens per item and checks them in order against the output channel.
module tb_indentation_token_lexer;

    localparam int LW = itl_pkg::LEVEL_W;
    localparam int TW = itl_pkg::TAB_W;
    localparam int DW = itl_pkg::DATA_W;
    localparam logic [2:0] REG_TAB_WIDTH = 3'd0;
    localparam int STACK_CAP = (itl_pkg::STACK_DEPTH_DEF < itl_pkg::MAX_TOKENS)
                             ? itl_pkg::STACK_DEPTH_DEF : itl_pkg::MAX_TOKENS;
    localparam int SETTLE_CYCLES = 2 * itl_pkg::MAX_TOKENS + 8;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 50;

    typedef struct {
        itl_pkg::t_kind     kind;
        logic [LW-1:0]      level;
        logic               last;
    } t_lex_token;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [7:0]          i_char_code;
    logic                i_at_end;
    logic                i_externals_enabled;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [1:0]          o_token_kind;
    logic [LW-1:0]       o_indent_level;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [DW-1:0]       pwdata;
    logic [DW-1:0]       prdata;
    logic                pready;

    // predicted lexer state
    logic [LW-1:0]       lvl_stack [STACK_CAP];
    int unsigned         lvl_count;
    bit                  in_margin;
    int unsigned         margin_width;
    bit                  end_seen;
    logic [TW-1:0]       tab_cols;

    t_lex_token          expected_tokens [$];
    int                  fails;
    int                  items_sent;
    int unsigned         cycle_count;

    indentation_token_lexer dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_char_code         (i_char_code),
        .i_at_end            (i_at_end),
        .i_externals_enabled (i_externals_enabled),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_token_kind        (o_token_kind),
        .o_indent_level      (o_indent_level),
        .o_last              (o_last),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [LW-1:0] lvl_top();
        return lvl_stack[lvl_count - 1];
    endfunction

    function automatic void queue_token(itl_pkg::t_kind kind, bit is_last);
        t_lex_token t;
        t.kind  = kind;
        t.level = lvl_top();
        t.last  = is_last;
        expected_tokens.push_back(t);
    endfunction

    function automatic void reset_lexer_model();
        lvl_stack[0] = '0;
        lvl_count    = 1;
        in_margin    = 1'b0;
        margin_width = 0;
        end_seen     = 1'b0;
        tab_cols     = itl_pkg::TAB_RESET;
    endfunction

    function automatic void unwind_to_base();
        int unsigned pops;
        pops = lvl_count - 1;
        lvl_count = 1;
        queue_token(itl_pkg::KIND_NEWLINE, pops == 0);
        for (int unsigned i = 0; i < pops; i++)
            queue_token(itl_pkg::KIND_DEDENT, i == pops - 1);
        end_seen = 1'b1;
    endfunction

    function automatic void close_margin();
        int unsigned pops;
        pops = 0;
        in_margin = 1'b0;
        if (margin_width > lvl_top()) begin
            queue_token(itl_pkg::KIND_NEWLINE, 1'b0);
            // full stack: INDENT still goes out, top stays as it was
            if (lvl_count < STACK_CAP) begin
                lvl_stack[lvl_count] = LW'(margin_width);
                lvl_count++;
            end
            queue_token(itl_pkg::KIND_INDENT, 1'b1);
        end else begin
            // all pops happen first, so every token reports the final top
            while (lvl_count > 1 && lvl_top() > margin_width) begin
                lvl_count--;
                pops++;
            end
            queue_token(itl_pkg::KIND_NEWLINE, pops == 0);
            for (int unsigned i = 0; i < pops; i++)
                queue_token(itl_pkg::KIND_DEDENT, i == pops - 1);
        end
    endfunction

    function automatic void predict_tokens(logic [7:0] ch, logic at_end, logic enabled);
        if (enabled) begin
            if (!in_margin) begin
                if (at_end) begin
                    if (!end_seen)
                        unwind_to_base();
                end else if (ch == itl_pkg::CHAR_LF) begin
                    in_margin    = 1'b1;
                    margin_width = 0;
                end
            end else if (at_end) begin
                in_margin = 1'b0;
                unwind_to_base();
            end else if (ch == itl_pkg::CHAR_LF) begin
                margin_width = 0;
            end else if (ch == itl_pkg::CHAR_SPACE || ch == itl_pkg::CHAR_TAB) begin
                margin_width += (ch == itl_pkg::CHAR_SPACE) ? 1 : int'(tab_cols);
                if (margin_width > itl_pkg::WIDTH_MAX)
                    margin_width = itl_pkg::WIDTH_MAX;
            end else begin
                close_margin();
            end
        end
    endfunction

    // ---------------------------------------------------------------- token checker

    always @(posedge i_clk) begin : token_check
        t_lex_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: kind %0d level %0d last %0d",
                       o_token_kind, o_indent_level, o_last);
                fails++;
            end else begin
                want = expected_tokens.pop_front();
                if (o_token_kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                    fails++;
                end
                if (o_indent_level !== want.level) begin
                    $error("indent_level: expected %0d, got %0d", want.level, o_indent_level);
                    fails++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fails++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- output stall

    initial begin : out_stall_gen
        int  r;
        int  run;
        logic level;
        i_out_stall = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                level = 1'b0;
                run   = $urandom_range(1, 16);
            end else if (r < 90) begin
                level = 1'b1;
                run   = $urandom_range(1, 3);
            end else begin
                level = 1'b1;
                run   = $urandom_range(8, 30);
            end
            repeat (run) begin
                @(negedge i_clk);
                i_out_stall = level;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [7:0] ch, input logic at_end, input logic enabled);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid          = 1'b1;
        i_char_code         = ch;
        i_at_end            = at_end;
        i_externals_enabled = enabled;
        do @(posedge i_clk); while (o_in_stall);
        predict_tokens(ch, at_end, enabled);
        if (enabled)
            items_sent++;
    endtask

    // drop valid, drain all tokens, then give the block time to go idle
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write then read back; the read follows straight on from the write
    task automatic set_tab_width(input logic [TW-1:0] cols);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_TAB_WIDTH;
        pwdata  = DW'(cols);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tab_cols = cols;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[TW-1:0] !== cols) begin
            $error("tab_width: expected %0d, got %0d", cols, prdata[TW-1:0]);
            fails++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [7:0] content_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == itl_pkg::CHAR_LF || c == itl_pkg::CHAR_SPACE || c == itl_pkg::CHAR_TAB);
        return c;
    endfunction

    function automatic logic [7:0] non_lf_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == itl_pkg::CHAR_LF);
        return c;
    endfunction

    task automatic send_ws();
        send_item(($urandom_range(0, 2) == 0) ? itl_pkg::CHAR_TAB : itl_pkg::CHAR_SPACE,
                  1'b0, 1'b1);
    endtask

    // disabled items must leave the state alone, whatever they carry
    task automatic maybe_noise();
        if ($urandom_range(0, 11) == 0)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic send_line();
        int n_ws;
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 3)) send_ws();
            send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        end
        n_ws = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
        repeat (n_ws) begin
            maybe_noise();
            send_ws();
        end
        if ($urandom_range(0, 24) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end else begin
            send_item(content_byte(), 1'b0, 1'b1);
            repeat ($urandom_range(0, 3)) begin
                maybe_noise();
                send_item(non_lf_byte(), 1'b0, 1'b1);
            end
            if ($urandom_range(0, 29) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);                   // content outside a line start
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        send_item(itl_pkg::CHAR_SPACE, 1'b0, 1'b1);
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);        // blank line restarts the count
        send_item(itl_pkg::CHAR_TAB, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);                   // indent to 4
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        send_item(itl_pkg::CHAR_SPACE, 1'b0, 1'b0);     // disabled, ignored
        send_item(itl_pkg::CHAR_TAB, 1'b0, 1'b1);
        send_item(itl_pkg::CHAR_SPACE, 1'b0, 1'b1);
        send_item(8'h78, 1'b0, 1'b1);                   // indent to 5
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        repeat (4) send_item(itl_pkg::CHAR_SPACE, 1'b0, 1'b1);
        send_item(8'h79, 1'b0, 1'b1);                   // back to 4, one dedent
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        send_item(8'h7A, 1'b0, 1'b1);                   // column zero, one dedent
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        send_item(itl_pkg::CHAR_SPACE, 1'b0, 1'b1);
        send_item(8'h77, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);                   // disabled end
        send_item(8'h00, 1'b1, 1'b1);                   // end unwinds
        send_item(8'h5A, 1'b1, 1'b1);                   // repeated end: nothing
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        send_item(itl_pkg::CHAR_LF, 1'b1, 1'b1);        // end inside a margin still yields tokens
        send_item(8'h71, 1'b0, 1'b1);                   // bytes after end
        settle();
    endtask

    // staircase of eight levels, then one line at column zero pops them all
    task automatic test_deep_stack();
        set_tab_width(5'd3);
        for (int k = 1; k <= 8; k++) begin
            send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
            for (int j = 0; j < k; j++)
                send_item(j[0] ? itl_pkg::CHAR_TAB : itl_pkg::CHAR_SPACE, 1'b0, 1'b1);
            send_item(content_byte(), 1'b0, 1'b1);
        end
        send_item(itl_pkg::CHAR_LF, 1'b0, 1'b1);
        send_item(content_byte(), 1'b0, 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        settle();
    endtask

    task automatic test_random_lines();
        logic [TW-1:0] widths [4];
        int target;
        widths[0] = TW'($urandom_range(2, 15));
        widths[1] = 5'd1;
        widths[2] = 5'd16;
        widths[3] = TW'($urandom_range(1, 16));
        foreach (widths[p]) begin
            set_tab_width(widths[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_line();
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            settle();
        end
    endtask

    initial begin
        i_in_valid          = 1'b0;
        i_char_code         = '0;
        i_at_end            = 1'b0;
        i_externals_enabled = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = REG_TAB_WIDTH;
        pwdata              = '0;
        i_rst_n             = 1'b0;
        fails               = 0;
        items_sent          = 0;
        cycle_count         = 0;
        reset_lexer_model();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_deep_stack();
        test_random_lines();

        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: indentation_token_lexer.f
hw/rtl/itl_pkg.sv
hw/rtl/itl_cell.sv
hw/rtl/indentation_token_lexer.sv
tb/sv/tb_indentation_token_lexer.sv
